// ===== sv/apc_pkg.sv =====
// ----------------------------------------------------------------------------
// apc_pkg
// Shared widths, operation codes and controller/datapath interface types
// for the absolute Pearson correlation block.
// ----------------------------------------------------------------------------
package apc_pkg;

    localparam int DATA_W  = 16;
    localparam int CNT_W   = 17;
    localparam int SUM_W   = 33;
    localparam int SQ_W    = 47;
    localparam int XS_W    = 48;
    localparam int WORD_W  = 64;
    localparam int OPA_W   = 128;
    localparam int PROD_W  = OPA_W + WORD_W;
    localparam int Q_W     = 16;
    localparam int BIT_W   = 4;
    localparam int OP_W    = 4;

    localparam logic [Q_W-1:0] Q_ONE = 16'd32768;

    localparam logic [OP_W-1:0] OP_N_SXY   = 4'd0;
    localparam logic [OP_W-1:0] OP_SX_SY   = 4'd1;
    localparam logic [OP_W-1:0] OP_N_SXX   = 4'd2;
    localparam logic [OP_W-1:0] OP_SX_SX   = 4'd3;
    localparam logic [OP_W-1:0] OP_N_SYY   = 4'd4;
    localparam logic [OP_W-1:0] OP_SY_SY   = 4'd5;
    localparam logic [OP_W-1:0] OP_MAG_MAG = 4'd6;
    localparam logic [OP_W-1:0] OP_VX_VY   = 4'd7;
    localparam logic [OP_W-1:0] OP_TRIAL   = 4'd8;

    typedef struct packed {
        logic             accept;
        logic             mul_start;
        logic             store;
        logic             clear_q;
        logic             load_out;
        logic [OP_W-1:0]  op;
        logic [BIT_W-1:0] bit_idx;
    } apc_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic mul_busy;
        logic degen;
        logic skip;
        logic out_full;
    } apc_status_t;

endpackage

// ===== sv/apc_mul.sv =====
// ----------------------------------------------------------------------------
// apc_mul
// Shift-and-add multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module apc_mul #(
    parameter int A_W = 128,
    parameter int B_W = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               busy,
    output logic               done,
    output logic [A_W+B_W-1:0] product
);
    localparam int P_W = A_W + B_W;

    logic           busy_reg;
    logic [P_W-1:0] a_reg;
    logic [B_W-1:0] b_reg;
    logic [P_W-1:0] acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && (b_reg == '0))
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= P_W'(a);
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg && (b_reg != '0))
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign busy    = busy_reg;
    assign done    = busy_reg && (b_reg == '0);
    assign product = acc_reg;

endmodule

// ===== sv/apc_datapath.sv =====
// ----------------------------------------------------------------------------
// apc_datapath
// Window accumulators, variance and covariance terms, the digit-by-digit
// search for the coefficient and the output register.
// ----------------------------------------------------------------------------
module apc_datapath #(
    parameter int MAX_PAIRS   = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  apc_pkg::apc_cmd_t                   cmd,
    output apc_pkg::apc_status_t                status,
    input  logic signed [apc_pkg::DATA_W-1:0]   ref_sample,
    input  logic signed [apc_pkg::DATA_W-1:0]   flt_sample,
    input  logic                                ref_missing,
    input  logic                                flt_missing,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [apc_pkg::Q_W-1:0]             abs_corr,
    output logic                                degenerate,
    output logic [apc_pkg::CNT_W-1:0]           pair_count
);
    import apc_pkg::*;

    localparam int SH = DATA_W - SAMPLE_BITS;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAIRS);

    logic [CNT_W-1:0]        count_reg;
    logic signed [SUM_W-1:0] sx_reg, sy_reg;
    logic [SQ_W-1:0]         sxx_reg, syy_reg;
    logic signed [XS_W-1:0]  sxy_reg;

    logic [WORD_W-1:0] t0_reg, num_reg, vx_reg, vy_reg;
    logic [PROD_W-1:0] rhs_reg;
    logic [OPA_W-1:0]  pp_reg;
    logic [Q_W-1:0]    q_reg;

    logic           out_valid_reg;
    logic [Q_W-1:0] abs_corr_reg;
    logic           degenerate_reg;
    logic [CNT_W-1:0] pair_count_reg;

    logic signed [DATA_W-1:0]   x, y;
    logic signed [2*DATA_W-1:0] xx, yy, xy;
    logic                       take;
    logic [WORD_W-1:0]          mag, diff;
    logic [Q_W-1:0]             trial;
    logic [Q_W-1:0]             d;
    logic [2*Q_W-1:0]           d2;
    logic [OPA_W-1:0]           op_a;
    logic [WORD_W-1:0]          op_b;
    logic                       mul_busy, mul_done;
    logic [PROD_W-1:0]          prod;
    logic                       degen;

    assign x  = DATA_W'($signed(ref_sample <<< SH) >>> SH);
    assign y  = DATA_W'($signed(flt_sample <<< SH) >>> SH);
    assign xx = x * x;
    assign yy = y * y;
    assign xy = x * y;
    assign take = cmd.accept && !ref_missing && !flt_missing && (count_reg < MAX_CNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            syy_reg   <= '0;
            sxy_reg   <= '0;
        end
        else if (cmd.load_out)
        begin
            count_reg <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            syy_reg   <= '0;
            sxy_reg   <= '0;
        end
        else if (take)
        begin
            count_reg <= count_reg + CNT_W'(1);
            sx_reg    <= sx_reg + SUM_W'(x);
            sy_reg    <= sy_reg + SUM_W'(y);
            sxx_reg   <= sxx_reg + SQ_W'(unsigned'(xx));
            syy_reg   <= syy_reg + SQ_W'(unsigned'(yy));
            sxy_reg   <= sxy_reg + XS_W'(xy);
        end
    end

    assign trial = q_reg | (Q_W'(1) << cmd.bit_idx);
    assign d     = Q_W'({1'b0, trial, 1'b0} - (Q_W+2)'(2)) | Q_W'(1);
    assign d2    = d * d;

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (cmd.op)
            OP_N_SXY:
            begin
                op_a = OPA_W'(count_reg);
                op_b = WORD_W'(sxy_reg);
            end
            OP_SX_SY:
            begin
                op_a = OPA_W'(unsigned'(WORD_W'(sx_reg)));
                op_b = WORD_W'(sy_reg);
            end
            OP_N_SXX:
            begin
                op_a = OPA_W'(count_reg);
                op_b = WORD_W'(sxx_reg);
            end
            OP_SX_SX:
            begin
                op_a = OPA_W'(unsigned'(WORD_W'(sx_reg)));
                op_b = WORD_W'(sx_reg);
            end
            OP_N_SYY:
            begin
                op_a = OPA_W'(count_reg);
                op_b = WORD_W'(syy_reg);
            end
            OP_SY_SY:
            begin
                op_a = OPA_W'(unsigned'(WORD_W'(sy_reg)));
                op_b = WORD_W'(sy_reg);
            end
            OP_MAG_MAG:
            begin
                op_a = OPA_W'(mag);
                op_b = mag;
            end
            OP_VX_VY:
            begin
                op_a = OPA_W'(vx_reg);
                op_b = vy_reg;
            end
            OP_TRIAL:
            begin
                op_a = pp_reg;
                op_b = WORD_W'(d2);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    apc_mul #(
        .A_W(OPA_W),
        .B_W(WORD_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (op_a),
        .b       (op_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (prod)
    );

    assign mag  = num_reg[WORD_W-1] ? (WORD_W'(0) - num_reg) : num_reg;
    assign diff = t0_reg - prod[WORD_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.clear_q)
        begin
            q_reg <= '0;
        end
        if (cmd.store)
        begin
            case (cmd.op)
                OP_N_SXY, OP_N_SXX, OP_N_SYY:
                begin
                    t0_reg <= prod[WORD_W-1:0];
                end
                OP_SX_SY:
                begin
                    num_reg <= diff;
                end
                OP_SX_SX:
                begin
                    vx_reg <= diff;
                end
                OP_SY_SY:
                begin
                    vy_reg <= diff;
                end
                OP_MAG_MAG:
                begin
                    rhs_reg <= {prod[PROD_W-33:0], 32'h0};
                end
                OP_VX_VY:
                begin
                    pp_reg <= prod[OPA_W-1:0];
                end
                OP_TRIAL:
                begin
                    if (prod <= rhs_reg)
                    begin
                        q_reg <= trial;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign degen = (count_reg == '0) || (vx_reg == '0) || (vy_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            abs_corr_reg   <= degen ? '0 : q_reg;
            degenerate_reg <= degen;
            pair_count_reg <= count_reg;
        end
    end

    assign status.mul_done = mul_done;
    assign status.mul_busy = mul_busy;
    assign status.degen    = degen;
    assign status.skip     = trial > Q_ONE;
    assign status.out_full = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign abs_corr   = abs_corr_reg;
    assign degenerate = degenerate_reg;
    assign pair_count = pair_count_reg;

endmodule

// ===== sv/apc_ctrl.sv =====
// ----------------------------------------------------------------------------
// apc_ctrl
// Sequencer that accepts sample pairs and, at a window end, steps the
// datapath through the products and the coefficient search.
// ----------------------------------------------------------------------------
module apc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 window_end,
    output logic                 in_ready,
    input  apc_pkg::apc_status_t status,
    output apc_pkg::apc_cmd_t    cmd
);
    import apc_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_START  = 3'd1;
    localparam logic [2:0] ST_WAIT   = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [OP_W-1:0]  op_reg, op_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic             accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        bit_next      = bit_reg;
        cmd.accept    = accept;
        cmd.mul_start = 1'b0;
        cmd.store     = 1'b0;
        cmd.clear_q   = 1'b0;
        cmd.load_out  = 1'b0;
        cmd.op        = op_reg;
        cmd.bit_idx   = bit_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && window_end)
                begin
                    cmd.clear_q = 1'b1;
                    op_next     = OP_N_SXY;
                    state_next  = ST_START;
                end
            end
            ST_START:
            begin
                if ((op_reg == OP_TRIAL) && status.skip)
                begin
                    if (bit_reg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        bit_next = bit_reg - BIT_W'(1);
                    end
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (status.mul_done)
                begin
                    cmd.store  = 1'b1;
                    state_next = ST_START;
                    case (op_reg)
                        OP_N_SXY:   op_next = OP_SX_SY;
                        OP_SX_SY:   op_next = OP_N_SXX;
                        OP_N_SXX:   op_next = OP_SX_SX;
                        OP_SX_SX:   op_next = OP_N_SYY;
                        OP_N_SYY:   op_next = OP_SY_SY;
                        OP_SY_SY:   state_next = ST_CHECK;
                        OP_MAG_MAG: op_next = OP_VX_VY;
                        OP_VX_VY:
                        begin
                            op_next  = OP_TRIAL;
                            bit_next = BIT_W'(Q_W - 1);
                        end
                        OP_TRIAL:
                        begin
                            if (bit_reg == '0)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                bit_next = bit_reg - BIT_W'(1);
                            end
                        end
                        default:    state_next = ST_FINISH;
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (status.degen)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    op_next    = OP_MAG_MAG;
                    state_next = ST_START;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_full)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_N_SXY;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            bit_reg   <= bit_next;
        end
    end

endmodule

// ===== sv/abs_pearson_correlation.sv =====
// ----------------------------------------------------------------------------
// abs_pearson_correlation
// Absolute Pearson correlation of sample pairs over a window.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one sample pair per transaction
// with its missing flags and a window_end mark. Pairs with a missing sample
// are skipped, as are pairs once MAX_PAIRS have been counted; the rest are
// summed at one transaction per cycle while the block is idle.
// A transaction with window_end set is summed and then closes the window:
// the block stops accepting input while it forms the result with one shared
// shift-and-add multiplier. Six products set up the variance and covariance
// terms; unless the window is degenerate, two more and up to sixteen trial
// products decide the Q1.15 result bit by bit.
// The output channel (out_valid/out_ready) holds abs_corr, degenerate and
// pair_count in a register; new pairs keep being accepted while a result
// waits. If the receiver stalls when the next window's result is ready, the
// block waits in that final step with input closed.
// Reset clears the window sums, the count and out_valid.
// ----------------------------------------------------------------------------
module abs_pearson_correlation #(
    parameter int MAX_PAIRS   = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [apc_pkg::DATA_W-1:0] ref_sample,
    input  logic signed [apc_pkg::DATA_W-1:0] flt_sample,
    input  logic                              ref_missing,
    input  logic                              flt_missing,
    input  logic                              window_end,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [apc_pkg::Q_W-1:0]           abs_corr,
    output logic                              degenerate,
    output logic [apc_pkg::CNT_W-1:0]         pair_count
);
    import apc_pkg::*;

    apc_cmd_t    cmd;
    apc_status_t status;

    apc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .window_end (window_end),
        .in_ready   (in_ready),
        .status     (status),
        .cmd        (cmd)
    );

    apc_datapath #(
        .MAX_PAIRS   (MAX_PAIRS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .ref_sample  (ref_sample),
        .flt_sample  (flt_sample),
        .ref_missing (ref_missing),
        .flt_missing (flt_missing),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .abs_corr    (abs_corr),
        .degenerate  (degenerate),
        .pair_count  (pair_count)
    );

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |-> !status.mul_busy)
        else $error("Multiplier started while busy.");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || out_ready))
        else $error("Result overwrote a pending transaction.");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |-> (abs_corr == '0))
        else $error("Degenerate result with nonzero coefficient.");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pair_count <= CNT_W'(MAX_PAIRS)))
        else $error("Pair count beyond the window limit.");

endmodule
